/* rtl/stuffed_frame_receiver_macros.svh */
`ifndef STUFFED_FRAME_RECEIVER_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

/* rtl/sfr_pkg.sv */
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int REG_IDX_W   = 3;
  localparam int STATUS_W    = 3;
  localparam int MAX_PAYLOAD_DEF = 256;

  localparam logic [REG_IDX_W-1:0] REG_FLAG_BYTE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_BYTE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLAG_CODE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CODE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS_BYTE = 3'd4;

  localparam logic [BYTE_W-1:0] RST_FLAG_BYTE    = 8'h7E;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] RST_FLAG_CODE    = 8'h5E;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE  = 8'h5D;
  localparam logic [BYTE_W-1:0] RST_ADDRESS_BYTE = 8'h03;

  localparam logic [BYTE_W-1:0] SEQ_ZERO_CTRL = 8'h00;
  localparam logic [BYTE_W-1:0] SEQ_ONE_CTRL  = 8'h40;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDRESS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG_SEQ   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HDR_CHECK   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PAY_CHECK   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SHORT       = 3'd6;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] flag_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] address_byte;
  } cfg_t;

  typedef struct packed {
    logic              is_flag;
    logic              escape_next;
    logic              bad_escape;
    logic              data_valid;
    logic [BYTE_W-1:0] data;
  } destuff_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                is_status;
    logic [STATUS_W-1:0] frame_status;
    logic                next_seq;
  } res_t;

endpackage

/* rtl/sfr_stream_if.sv */
interface sfr_line_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] line_byte;
  modport source (output valid, output line_byte, input ready);
  modport sink (input valid, input line_byte, output ready);
endinterface

interface sfr_result_if;
  import sfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_byte;
  logic                is_status;
  logic [STATUS_W-1:0] frame_status;
  logic                next_seq;
  modport source (output valid, output data_byte, output is_status, output frame_status,
                  output next_seq, input ready);
  modport sink (input valid, input data_byte, input is_status, input frame_status,
                input next_seq, output ready);
endinterface

/* rtl/sfr_destuff.sv */
module sfr_destuff (
  input  logic [sfr_pkg::BYTE_W-1:0] line_byte,
  input  logic                       escape_pending,
  input  sfr_pkg::cfg_t              cfg,
  output sfr_pkg::destuff_t          ds
);
  import sfr_pkg::*;

  always_comb begin
    ds             = '0;
    ds.is_flag     = (line_byte == cfg.flag_byte);
    if (escape_pending) begin
      if (line_byte == cfg.flag_code) begin
        ds.data_valid = 1'b1;
        ds.data       = cfg.flag_byte;
      end else if (line_byte == cfg.escape_code) begin
        ds.data_valid = 1'b1;
        ds.data       = cfg.escape_byte;
      end else begin
        ds.bad_escape = 1'b1;
      end
    end else if (line_byte == cfg.escape_byte) begin
      ds.escape_next = 1'b1;
    end else begin
      ds.data_valid = 1'b1;
      ds.data       = line_byte;
    end
  end

endmodule

/* rtl/sfr_frame.sv */
module sfr_frame #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [sfr_pkg::BYTE_W-1:0] line_byte,
  input  sfr_pkg::cfg_t              cfg,
  output logic                       res_valid,
  output sfr_pkg::res_t              res
);
  import sfr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD + 5);
  localparam logic [IDX_W-1:0] LIMIT_INDEX = IDX_W'(MAX_PAYLOAD + 4);

  logic                in_frame, in_frame_next;
  logic                escape_pending, escape_pending_next;
  logic [IDX_W-1:0]    byte_index, byte_index_next;
  logic [BYTE_W-1:0]   address_seen, address_seen_next;
  logic [BYTE_W-1:0]   control_seen, control_seen_next;
  logic [BYTE_W-1:0]   delayed_byte, delayed_byte_next;
  logic [BYTE_W-1:0]   payload_xor, payload_xor_next;
  logic [STATUS_W-1:0] first_error, first_error_next;
  logic                expected_seq, expected_seq_next;
  logic [STATUS_W-1:0] st;
  logic [BYTE_W-1:0]   want_ctrl;
  destuff_t            ds;

  sfr_destuff u_destuff (
    .line_byte      (line_byte),
    .escape_pending (escape_pending),
    .cfg            (cfg),
    .ds             (ds)
  );

  always_comb begin
    if (first_error != ST_OK)                  st = first_error;
    else if (escape_pending)                   st = ST_BAD_ESCAPE;
    else if (byte_index < IDX_W'(4))           st = ST_SHORT;
    else if (payload_xor != '0)                st = ST_PAY_CHECK;
    else                                       st = ST_OK;
  end

  assign want_ctrl = expected_seq ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    byte_index_next     = byte_index;
    address_seen_next   = address_seen;
    control_seen_next   = control_seen;
    delayed_byte_next   = delayed_byte;
    payload_xor_next    = payload_xor;
    first_error_next    = first_error;
    expected_seq_next   = expected_seq;
    res_valid           = 1'b0;
    res                 = '0;
    res.next_seq        = expected_seq;
    if (take) begin
      if (!in_frame || (ds.is_flag && !(byte_index == '0 && !escape_pending))) begin
        if (ds.is_flag) begin
          // open or close: both start from a clean frame
          escape_pending_next = 1'b0;
          byte_index_next     = '0;
          address_seen_next   = '0;
          control_seen_next   = '0;
          delayed_byte_next   = '0;
          payload_xor_next    = '0;
          first_error_next    = ST_OK;
          in_frame_next       = !in_frame;
          if (in_frame) begin
            expected_seq_next = expected_seq ^ (st == ST_OK);
            res_valid         = 1'b1;
            res.is_status     = 1'b1;
            res.frame_status  = st;
            res.next_seq      = expected_seq ^ (st == ST_OK);
          end
        end
      end else if (!ds.is_flag) begin
        escape_pending_next = ds.escape_next;
        if (ds.bad_escape && first_error == ST_OK) first_error_next = ST_BAD_ESCAPE;
        if (ds.data_valid) begin
          if (byte_index >= LIMIT_INDEX) begin
            if (first_error == ST_OK) first_error_next = ST_TOO_LONG;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
            case (byte_index)
              IDX_W'(0): begin
                address_seen_next = ds.data;
                if (ds.data != cfg.address_byte && first_error == ST_OK)
                  first_error_next = ST_BAD_ADDRESS;
              end
              IDX_W'(1): begin
                control_seen_next = ds.data;
                if (ds.data != want_ctrl && first_error == ST_OK)
                  first_error_next = ST_WRONG_SEQ;
              end
              IDX_W'(2): begin
                if ((address_seen ^ control_seen) != ds.data && first_error == ST_OK)
                  first_error_next = ST_HDR_CHECK;
              end
              default: begin
                if (byte_index >= IDX_W'(4) && first_error == ST_OK) begin
                  res_valid     = 1'b1;
                  res.data_byte = delayed_byte;
                end
                delayed_byte_next = ds.data;
                payload_xor_next  = payload_xor ^ ds.data;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      byte_index     <= '0;
      address_seen   <= '0;
      control_seen   <= '0;
      delayed_byte   <= '0;
      payload_xor    <= '0;
      first_error    <= ST_OK;
      expected_seq   <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      byte_index     <= byte_index_next;
      address_seen   <= address_seen_next;
      control_seen   <= control_seen_next;
      delayed_byte   <= delayed_byte_next;
      payload_xor    <= payload_xor_next;
      first_error    <= first_error_next;
      expected_seq   <= expected_seq_next;
    end
  end

endmodule

/* rtl/sfr_out_buf.sv */
module sfr_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::res_t push_data,
  input  logic          pop_ready,
  output logic          out_valid,
  output sfr_pkg::res_t out_data,
  output logic          full
);
  import sfr_pkg::*;

  res_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/stuffed_frame_receiver.sv */
// Each result beat is written into the result buffer when the line beat that causes it is taken.
// Throughput: one line beat per cycle while the result buffer is not full; frame state updates in a single pass.
// A two-entry result buffer keeps input open while one result waits.
// Reset (rst, synchronous): registers back to defaults, receiver hunts for a flag,
// sequence bit 0, result buffer empty.
module stuffed_frame_receiver #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  sfr_line_if.sink                      line,
  sfr_result_if.source                  result,
  input  logic                          write_en,
  input  logic [sfr_pkg::REG_IDX_W-1:0] write_index,
  input  logic [sfr_pkg::BYTE_W-1:0]    write_data
);
  import sfr_pkg::*;

  cfg_t cfg;
  logic take;
  logic full;
  logic frm_valid;
  res_t frm_res;
  res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte    <= RST_FLAG_BYTE;
      cfg.escape_byte  <= RST_ESCAPE_BYTE;
      cfg.flag_code    <= RST_FLAG_CODE;
      cfg.escape_code  <= RST_ESCAPE_CODE;
      cfg.address_byte <= RST_ADDRESS_BYTE;
    end else if (write_en) begin
      case (write_index)
        REG_FLAG_BYTE:    cfg.flag_byte    <= write_data;
        REG_ESCAPE_BYTE:  cfg.escape_byte  <= write_data;
        REG_FLAG_CODE:    cfg.flag_code    <= write_data;
        REG_ESCAPE_CODE:  cfg.escape_code  <= write_data;
        REG_ADDRESS_BYTE: cfg.address_byte <= write_data;
        default: ;
      endcase
    end
  end

  assign line.ready = !full;
  assign take       = line.valid && !full;

  sfr_frame #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .line_byte (line.line_byte),
    .cfg       (cfg),
    .res_valid (frm_valid),
    .res       (frm_res)
  );

  sfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (frm_valid),
    .push_data (frm_res),
    .pop_ready (result.ready),
    .out_valid (result.valid),
    .out_data  (out_res),
    .full      (full)
  );

  assign result.data_byte    = out_res.data_byte;
  assign result.is_status    = out_res.is_status;
  assign result.frame_status = out_res.frame_status;
  assign result.next_seq     = out_res.next_seq;

endmodule

/* rtl/sfr_checker.sv */
`include "stuffed_frame_receiver_macros.svh"

module sfr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         line_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [sfr_pkg::BYTE_W-1:0]   data_byte,
  input logic                         is_status,
  input logic [sfr_pkg::STATUS_W-1:0] frame_status,
  input logic                         next_seq
);
  import sfr_pkg::*;

  `SFR_ASSERT_IMPL(a_reset_idle, $past(rst), !res_valid && line_ready)
  `SFR_ASSERT_IMPL(a_status_no_data, res_valid && is_status, data_byte == '0)
  `SFR_ASSERT_IMPL(a_data_status_ok, res_valid && !is_status, frame_status == ST_OK)
  `SFR_ASSERT_NEXT(a_hold, res_valid && !res_ready,
                   res_valid && $stable(data_byte) && $stable(is_status) &&
                   $stable(frame_status) && $stable(next_seq))

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .line_ready   (line.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .data_byte    (result.data_byte),
  .is_status    (result.is_status),
  .frame_status (result.frame_status),
  .next_seq     (result.next_seq)
);

/* tb/tb_stuffed_frame_receiver.sv */
module tb_stuffed_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;

  typedef enum int {
    FR_GOOD, FR_BAD_ADDRESS, FR_BAD_CONTROL, FR_BAD_HEADER, FR_BAD_CHECK,
    FR_BAD_ESCAPE, FR_ESCAPE_AT_CLOSE, FR_SHORT, FR_DOUBLE_FLAG, FR_NOISE
  } frame_kind_t;

  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'hFC,
    8'h7E,
    8'h55, 8'h7E, 8'h7D, 8'h7E,
    8'h7E, 8'h03, 8'h7D, 8'h11, 8'h7E,
    8'h7E, 8'h03, 8'h40, 8'h7E
  };

  class frame_scoreboard;
    cfg_t        regs;
    bit          in_frame;
    bit          esc_pending;
    int unsigned index;
    logic [7:0]  addr_seen;
    logic [7:0]  ctrl_seen;
    logic [7:0]  held_byte;
    logic [7:0]  pay_xor;
    logic [2:0]  first_err;
    bit          seq;
    res_t        awaited[$];
    int          errors;

    function new();
      regs.flag_byte    = RST_FLAG_BYTE;
      regs.escape_byte  = RST_ESCAPE_BYTE;
      regs.flag_code    = RST_FLAG_CODE;
      regs.escape_code  = RST_ESCAPE_CODE;
      regs.address_byte = RST_ADDRESS_BYTE;
      in_frame = 1'b0;
      seq = 1'b0;
      errors = 0;
      clear_frame();
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_FLAG_BYTE:    regs.flag_byte = val;
        REG_ESCAPE_BYTE:  regs.escape_byte = val;
        REG_FLAG_CODE:    regs.flag_code = val;
        REG_ESCAPE_CODE:  regs.escape_code = val;
        REG_ADDRESS_BYTE: regs.address_byte = val;
        default: ;
      endcase
    endfunction

    function void clear_frame();
      esc_pending = 1'b0;
      index = 0;
      addr_seen = 8'h00;
      ctrl_seen = 8'h00;
      held_byte = 8'h00;
      pay_xor = 8'h00;
      first_err = ST_OK;
    endfunction

    function void note_error(logic [2:0] code);
      if (first_err == ST_OK) first_err = code;
    endfunction

    function void push_result(logic [7:0] data, logic status, logic [2:0] code);
      res_t r;
      r.data_byte = data;
      r.is_status = status;
      r.frame_status = code;
      r.next_seq = seq;
      awaited.push_back(r);
    endfunction

    function void note_line_byte(logic [7:0] b);
      logic [7:0] d;
      logic [7:0] want;
      logic [2:0] st;
      if (!in_frame) begin
        if (b == regs.flag_byte) begin
          clear_frame();
          in_frame = 1'b1;
        end
        return;
      end
      if (b == regs.flag_byte) begin
        if (index == 0 && !esc_pending) return;
        if (first_err != ST_OK) st = first_err;
        else if (esc_pending) st = ST_BAD_ESCAPE;
        else if (index < 4) st = ST_SHORT;
        else if (pay_xor != 8'h00) st = ST_PAY_CHECK;
        else st = ST_OK;
        if (st == ST_OK) seq = ~seq;
        push_result(8'h00, 1'b1, st);
        clear_frame();
        in_frame = 1'b0;
        return;
      end
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == regs.flag_code) d = regs.flag_byte;
        else if (b == regs.escape_code) d = regs.escape_byte;
        else begin
          note_error(ST_BAD_ESCAPE);
          return;
        end
      end else if (b == regs.escape_byte) begin
        esc_pending = 1'b1;
        return;
      end else begin
        d = b;
      end
      if (index >= MAX_PAYLOAD + 4) begin
        note_error(ST_TOO_LONG);
        return;
      end
      case (index)
        0: begin
          addr_seen = d;
          if (d != regs.address_byte) note_error(ST_BAD_ADDRESS);
        end
        1: begin
          want = seq ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;
          ctrl_seen = d;
          if (d != want) note_error(ST_WRONG_SEQ);
        end
        2: begin
          if ((addr_seen ^ ctrl_seen) != d) note_error(ST_HDR_CHECK);
        end
        default: begin
          if (index >= 4 && first_err == ST_OK) push_result(held_byte, 1'b0, ST_OK);
          held_byte = d;
          pay_xor = pay_xor ^ d;
        end
      endcase
      index++;
    endfunction

    function string fmt_res(res_t r);
      return $sformatf("data=%h status=%b code=%0d seq=%b",
                       r.data_byte, r.is_status, r.frame_status, r.next_seq);
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %s",
                 $time, fmt_res(got));
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected %s, actual %s",
                 $time, fmt_res(want), fmt_res(got));
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic write_en;
  logic [REG_IDX_W-1:0] write_index;
  logic [BYTE_W-1:0] write_data;

  sfr_line_if   line_bus ();
  sfr_result_if result_bus ();

  stuffed_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .line        (line_bus),
    .result      (result_bus),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  frame_scoreboard sb;
  int items_sent;
  bit line_no_idle;
  bit sink_no_idle;
  logic [7:0] line_burst[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int gap;
    result_bus.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) sink_no_idle = !sink_no_idle;
      gap = sink_no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        result_bus.ready <= 1'b0;
      end
      @(negedge clk);
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  always @(posedge clk) begin : beat_monitor
    res_t beat;
    if (!rst && result_bus.valid && result_bus.ready) begin
      beat.data_byte = result_bus.data_byte;
      beat.is_status = result_bus.is_status;
      beat.frame_status = result_bus.frame_status;
      beat.next_seq = result_bus.next_seq;
      sb.check_beat(beat);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) line_no_idle = !line_no_idle;
    gap = line_no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      line_bus.valid <= 1'b0;
    end
    @(negedge clk);
    line_bus.valid <= 1'b1;
    line_bus.line_byte <= b;
    do @(posedge clk); while (!line_bus.ready);
    sb.note_line_byte(b);
    items_sent++;
  endtask

  task automatic send_burst();
    foreach (line_burst[i]) send_byte(line_burst[i]);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    line_bus.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // a byte can leave no result, so let the block settle past the last beat before the register writes
  task automatic apply_config(input cfg_t c);
    hold_until_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_FLAG_BYTE, c.flag_byte);
    write_reg(REG_ESCAPE_BYTE, c.escape_byte);
    write_reg(REG_FLAG_CODE, c.flag_code);
    write_reg(REG_ESCAPE_CODE, c.escape_code);
    write_reg(REG_ADDRESS_BYTE, c.address_byte);
    @(negedge clk);
    write_en <= 1'b0;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.flag_byte = 8'($urandom);
    do c.escape_byte = 8'($urandom); while (c.escape_byte == c.flag_byte);
    do c.flag_code = 8'($urandom); while (c.flag_code == c.flag_byte);
    do c.escape_code = 8'($urandom);
    while (c.escape_code == c.flag_byte || c.escape_code == c.flag_code);
    c.address_byte = 8'($urandom);
    return c;
  endfunction

  function automatic void build_frame(input frame_kind_t kind, input int pay_len);
    logic [7:0] body[$];
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] chk;
    logic [7:0] b;
    int cut;
    int bad_pos;
    line_burst.delete();
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom);
        if (b == sb.regs.flag_byte) b = ~b;
        line_burst.push_back(b);
      end
      return;
    end
    addr = sb.regs.address_byte;
    if (kind == FR_BAD_ADDRESS) addr = addr ^ 8'($urandom_range(1, 255));
    ctrl = sb.seq ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;
    if (kind == FR_BAD_CONTROL) ctrl = ctrl ^ 8'($urandom_range(1, 255));
    body.push_back(addr);
    body.push_back(ctrl);
    body.push_back((kind == FR_BAD_HEADER) ? (addr ^ ctrl ^ 8'($urandom_range(1, 255)))
                                           : (addr ^ ctrl));
    chk = 8'h00;
    repeat (pay_len) begin
      if ($urandom_range(0, 7) == 0)
        b = $urandom_range(0, 1) ? sb.regs.flag_byte : sb.regs.escape_byte;
      else
        b = 8'($urandom);
      chk = chk ^ b;
      body.push_back(b);
    end
    if (kind == FR_BAD_CHECK) chk = chk ^ 8'($urandom_range(1, 255));
    body.push_back(chk);
    if (kind == FR_SHORT) begin
      cut = $urandom_range(1, 3);
      while (body.size() > cut) void'(body.pop_back());
    end
    bad_pos = $urandom_range(0, body.size() - 1);
    line_burst.push_back(sb.regs.flag_byte);
    if (kind == FR_DOUBLE_FLAG) line_burst.push_back(sb.regs.flag_byte);
    foreach (body[i]) begin
      if (kind == FR_BAD_ESCAPE && i == bad_pos) begin
        line_burst.push_back(sb.regs.escape_byte);
        do b = 8'($urandom);
        while (b == sb.regs.flag_byte || b == sb.regs.flag_code || b == sb.regs.escape_code);
        line_burst.push_back(b);
      end
      if (body[i] == sb.regs.flag_byte || body[i] == sb.regs.escape_byte) begin
        line_burst.push_back(sb.regs.escape_byte);
        line_burst.push_back((body[i] == sb.regs.flag_byte) ? sb.regs.flag_code
                                                            : sb.regs.escape_code);
      end else begin
        line_burst.push_back(body[i]);
      end
    end
    if (kind == FR_ESCAPE_AT_CLOSE) line_burst.push_back(sb.regs.escape_byte);
    line_burst.push_back(sb.regs.flag_byte);
  endfunction

  task automatic run_frames(input int budget);
    int stop;
    int pause_at;
    bit paused;
    frame_kind_t kind;
    int len;
    stop = items_sent + budget;
    pause_at = items_sent + $urandom_range(0, budget);
    paused = 1'b0;
    while (items_sent < stop) begin
      if (!paused && items_sent >= pause_at) begin
        paused = 1'b1;
        hold_until_drained();
      end
      if ($urandom_range(0, 99) < 55) kind = FR_GOOD;
      else kind = frame_kind_t'($urandom_range(1, 9));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
      build_frame(kind, len);
      send_burst();
    end
  endtask

  initial begin
    rst = 1'b1;
    write_en = 1'b0;
    write_index = REG_FLAG_BYTE;
    write_data = 8'h00;
    line_bus.valid = 1'b0;
    line_bus.line_byte = 8'h00;
    items_sent = 0;
    line_no_idle = 1'b0;
    sink_no_idle = 1'b0;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

    run_frames(150);
    // payload exactly at the limit, then one byte over
    build_frame(FR_GOOD, MAX_PAYLOAD);
    send_burst();
    build_frame(FR_GOOD, MAX_PAYLOAD + 1);
    send_burst();

    apply_config('{8'h00, 8'hFF, 8'hFF, 8'h01, 8'hFF});
    run_frames(150);
    apply_config('{8'hFF, 8'h00, 8'h00, 8'hFE, 8'h00});
    run_frames(150);
    // flag and escape share one value
    apply_config('{8'h7E, 8'h7E, 8'h5E, 8'h5D, 8'h03});
    run_frames(60);
    repeat (3) begin
      apply_config(random_regs());
      run_frames(90);
    end

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* stuffed_frame_receiver.f */
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_stream_if.sv
rtl/sfr_destuff.sv
rtl/sfr_frame.sv
rtl/sfr_out_buf.sv
rtl/stuffed_frame_receiver.sv
rtl/sfr_checker.sv
tb/tb_stuffed_frame_receiver.sv
